// ===== hdl/jtag_scan_sequencer_top_assert.svh =====
// Assertion macros for the JTAG scan sequencer checker.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef JTAG_SCAN_SEQUENCER_TOP_ASSERT_SVH
`define JTAG_SCAN_SEQUENCER_TOP_ASSERT_SVH

// Check a condition or implication on every clock edge outside reset
`define JSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a consequent holds in the cycle after the antecedent
`define JSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== hdl/jss_pkg.sv =====
// Shared types and constants for the JTAG scan sequencer.
// No dependencies; imported by jss_seq, jss_out_skid and the top level.
`default_nettype none

package jss_pkg;

    localparam int DATA_W       = 64;
    localparam int LEN_W        = 7;
    localparam int CODE_W       = 32;
    localparam int IRLEN_W      = 6;
    localparam int MAX_SCAN_DEF = 64;

    localparam logic [2:0]        RST_TMS_CYCLES = 3'd5;
    localparam logic [CODE_W-1:0] RESTART_RST    = 32'd4;
    localparam logic [IRLEN_W-1:0] IRLEN_RST     = 6'd4;

    // Command codes carried in the action field
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_IR    = 2'd2,
        ACT_DR    = 2'd3
    } jss_action_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_RESTART = 1'b0,
        CFG_IR_LEN  = 1'b1
    } jss_cfg_t;

    // Sequence phase, one-hot
    typedef enum logic [9:0] {
        PH_NONE     = 10'b00_0000_0001,
        PH_RST_TMS  = 10'b00_0000_0010,
        PH_RST_IDLE = 10'b00_0000_0100,
        PH_ENTER    = 10'b00_0000_1000,
        PH_SEL_IR   = 10'b00_0001_0000,
        PH_CAPTURE  = 10'b00_0010_0000,
        PH_TO_SHIFT = 10'b00_0100_0000,
        PH_SHIFT    = 10'b00_1000_0000,
        PH_UPDATE   = 10'b01_0000_0000,
        PH_PARK     = 10'b10_0000_0000
    } jss_phase_t;

    // One TCK cycle result
    typedef struct packed {
        logic              tms;
        logic              tdi;
        logic              shift_cycle;
        logic [DATA_W-1:0] captured;
        logic              last;
    } jss_result_t;

endpackage

`default_nettype wire

// ===== hdl/jss_seq.sv =====
// Sequencer core: TAP sequence state registers and their next-state logic.
// Depends on jss_pkg.
`default_nettype none

module jss_seq
    import jss_pkg::*;
#(
    parameter int MAX_SCAN = MAX_SCAN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [1:0]         action,
    input  wire logic [DATA_W-1:0]  scan_data,
    input  wire logic [LEN_W-1:0]   scan_length,
    input  wire logic               tdo,
    input  wire logic [CODE_W-1:0]  restart_code,
    input  wire logic [IRLEN_W-1:0] ir_length,
    output logic                    res_valid,
    output jss_result_t             res
);

    localparam int CNT_W = $clog2(MAX_SCAN + 1);
    localparam int IDX_W = $clog2(MAX_SCAN);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SCAN);

    jss_phase_t          phase_reg, phase_next;
    logic [CNT_W-1:0]    bit_count_reg, bit_count_next;
    logic [2:0]          reset_count_reg, reset_count_next;
    logic [DATA_W-1:0]   shift_out_reg, shift_out_next;
    logic [MAX_SCAN-1:0] shift_in_reg, shift_in_next;
    logic [CNT_W-1:0]    active_length_reg, active_length_next;
    logic                at_idle_reg, at_idle_next;
    logic                scan_is_ir_reg, scan_is_ir_next;

    logic [2:0]          rc_inc;
    logic [CNT_W-1:0]    bit_inc;

    // Force a length into the range one to MAX_SCAN
    function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] r;
        if (len == '0)
            r = CNT_W'(1);
        else if (len > MAX_LEN)
            r = CNT_W'(MAX_SCAN);
        else
            r = CNT_W'(len);
        return r;
    endfunction

    assign rc_inc  = reset_count_reg + 3'd1;
    assign bit_inc = bit_count_reg + CNT_W'(1);

    // Decode the transaction and advance the sequence
    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        reset_count_next   = reset_count_reg;
        shift_out_next     = shift_out_reg;
        shift_in_next      = shift_in_reg;
        active_length_next = active_length_reg;
        at_idle_next       = at_idle_reg;
        scan_is_ir_next    = scan_is_ir_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (accept)
        begin
            unique case (jss_action_t'(action))
                ACT_RESET:
                begin
                    shift_out_next     = DATA_W'(restart_code);
                    shift_in_next      = '0;
                    bit_count_next     = '0;
                    active_length_next = clamp_len({1'b0, ir_length});
                    scan_is_ir_next    = 1'b1;
                    at_idle_next       = 1'b1;
                    reset_count_next   = '0;
                    phase_next         = PH_RST_TMS;
                end
                ACT_IR:
                begin
                    shift_out_next     = scan_data;
                    shift_in_next      = '0;
                    bit_count_next     = '0;
                    active_length_next = clamp_len(scan_length);
                    scan_is_ir_next    = 1'b1;
                    at_idle_next       = (scan_data == DATA_W'(restart_code));
                    phase_next         = at_idle_reg ? PH_ENTER : PH_SEL_IR;
                end
                ACT_DR:
                begin
                    shift_out_next     = scan_data;
                    shift_in_next      = '0;
                    bit_count_next     = '0;
                    active_length_next = clamp_len(scan_length);
                    scan_is_ir_next    = 1'b0;
                    at_idle_next       = 1'b1;
                    phase_next         = at_idle_reg ? PH_ENTER : PH_CAPTURE;
                end
                ACT_TICK:
                begin
                    res_valid = (phase_reg != PH_NONE);
                    unique case (phase_reg)
                        PH_RST_TMS:
                        begin
                            res.tms = 1'b1;
                            if (rc_inc >= RST_TMS_CYCLES)
                            begin
                                reset_count_next = '0;
                                phase_next       = PH_RST_IDLE;
                            end
                            else
                            begin
                                reset_count_next = rc_inc;
                            end
                        end
                        PH_RST_IDLE:
                        begin
                            phase_next = PH_ENTER;
                        end
                        PH_ENTER:
                        begin
                            res.tms    = 1'b1;
                            phase_next = scan_is_ir_reg ? PH_SEL_IR : PH_CAPTURE;
                        end
                        PH_SEL_IR:
                        begin
                            res.tms    = 1'b1;
                            phase_next = PH_CAPTURE;
                        end
                        PH_CAPTURE:
                        begin
                            phase_next = PH_TO_SHIFT;
                        end
                        PH_TO_SHIFT:
                        begin
                            phase_next = PH_SHIFT;
                        end
                        PH_SHIFT:
                        begin
                            res.shift_cycle = 1'b1;
                            res.tdi         = shift_out_reg[0];
                            shift_out_next  = shift_out_reg >> 1;
                            shift_in_next[bit_count_reg[IDX_W-1:0]] =
                                shift_in_reg[bit_count_reg[IDX_W-1:0]] | tdo;
                            // Raise TMS on the final bit to leave Shift
                            if (bit_inc >= active_length_reg)
                            begin
                                res.tms    = 1'b1;
                                phase_next = PH_UPDATE;
                            end
                            bit_count_next = bit_inc;
                        end
                        PH_UPDATE:
                        begin
                            res.tms    = 1'b1;
                            phase_next = PH_PARK;
                        end
                        PH_PARK:
                        begin
                            res.tms      = ~at_idle_reg;
                            res.captured = DATA_W'(shift_in_reg);
                            res.last     = 1'b1;
                            phase_next   = PH_NONE;
                        end
                        default:
                        begin
                            phase_next = PH_NONE;
                        end
                    endcase
                end
            endcase
        end
    end

    // Hold sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_NONE;
            bit_count_reg     <= '0;
            reset_count_reg   <= '0;
            shift_out_reg     <= '0;
            shift_in_reg      <= '0;
            active_length_reg <= CNT_W'(1);
            at_idle_reg       <= 1'b1;
            scan_is_ir_reg    <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            reset_count_reg   <= reset_count_next;
            shift_out_reg     <= shift_out_next;
            shift_in_reg      <= shift_in_next;
            active_length_reg <= active_length_next;
            at_idle_reg       <= at_idle_next;
            scan_is_ir_reg    <= scan_is_ir_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jss_out_skid.sv =====
// Output stage: result register plus one skid entry toward the consumer.
// Depends on jss_pkg for the result type.
`default_nettype none

module jss_out_skid
    import jss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire jss_result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  wire logic        out_stall,
    output jss_result_t      out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    jss_result_t main_data_reg, main_data_next;
    jss_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop       = main_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Route a new result into the main register or the skid entry; a pop moves the skid entry up
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/jtag_scan_sequencer_top.sv =====
// JTAG scan sequencer, top level: configuration registers and handshakes.
// Depends on jss_pkg, jss_seq and jss_out_skid.
`default_nettype none

// One transaction is accepted per clock while in_stall is low. A command (reset
// sequence, instruction scan, data scan) loads the sequence and gives no result;
// each tick then drives one TCK cycle, whose result is registered in the output
// register or its skid entry. jss_seq handles a transaction combinationally, so
// the sustained rate is one transaction per cycle while out_stall is low.
// in_stall rises only when the output register and its skid entry both hold
// undelivered results. A reset sequence runs RST_TMS, RST_IDLE, ENTER, SEL_IR,
// CAPTURE, TO_SHIFT, SHIFT over ir_length bits, UPDATE and PARK. A scan starts
// at ENTER, past it when not at idle, adds SEL_IR for an instruction, shifts
// scan_length bits, then exits. Lengths are clamped to the range 1 to MAX_SCAN.
module jtag_scan_sequencer_top
    import jss_pkg::*;
#(
    parameter int MAX_SCAN = MAX_SCAN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [CODE_W-1:0]  cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [DATA_W-1:0]  scan_data,
    input  wire logic [LEN_W-1:0]   scan_length,
    input  wire logic               tdo,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    tms,
    output logic                    tdi,
    output logic                    shift_cycle,
    output logic [DATA_W-1:0]       captured,
    output logic                    last
);

    logic [CODE_W-1:0]  restart_code_reg;
    logic [IRLEN_W-1:0] ir_length_reg;
    logic               accept;
    logic               res_valid;
    logic               full;
    jss_result_t        res;
    jss_result_t        out_data;

    assign in_stall = full;
    assign accept   = in_valid & ~full;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_code_reg <= RESTART_RST;
            ir_length_reg    <= IRLEN_RST;
        end
        else if (cfg_write)
        begin
            unique case (jss_cfg_t'(cfg_index))
                CFG_RESTART: restart_code_reg <= cfg_data;
                CFG_IR_LEN:  ir_length_reg    <= cfg_data[IRLEN_W-1:0];
            endcase
        end
    end

    jss_seq #(
        .MAX_SCAN (MAX_SCAN)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .scan_data    (scan_data),
        .scan_length  (scan_length),
        .tdo          (tdo),
        .restart_code (restart_code_reg),
        .ir_length    (ir_length_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    jss_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Drive result ports
    assign tms         = out_data.tms;
    assign tdi         = out_data.tdi;
    assign shift_cycle = out_data.shift_cycle;
    assign captured    = out_data.captured;
    assign last        = out_data.last;

endmodule

`default_nettype wire

// ===== hdl/jss_checker.sv =====
// Port-level checker for the JTAG scan sequencer, bound to the top level.
// Depends on jtag_scan_sequencer_top_assert.svh for the assertion macros.
`default_nettype none

`include "jtag_scan_sequencer_top_assert.svh"

module jss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        tdi,
    input wire logic        shift_cycle,
    input wire logic [63:0] captured,
    input wire logic        last
);

    // Skid entry can fill only behind a waiting result
    `JSS_ASSERT(a_stall_needs_result, (in_stall |-> out_valid), "in_stall without a held result")
    // Captured bits appear only on the final cycle
    `JSS_ASSERT(a_capture_on_last, (out_valid && !last |-> captured == 64'd0), "captured nonzero before last")
    // TDI is quiet outside shift cycles
    `JSS_ASSERT(a_tdi_quiet, (out_valid && !shift_cycle |-> !tdi), "tdi high on non-shift cycle")
    // The final cycle parks the TAP and never shifts
    `JSS_ASSERT(a_last_no_shift, (out_valid && last |-> !shift_cycle), "shift on last cycle")
    // A stalled result holds
    `JSS_ASSERT_NEXT(a_stall_hold, (out_valid && out_stall), (out_valid && $stable(captured)), "stalled result changed")

endmodule

bind jtag_scan_sequencer_top jss_checker u_jss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tdi         (tdi),
    .shift_cycle (shift_cycle),
    .captured    (captured),
    .last        (last)
);

`default_nettype wire
